// File: hw/rtl/sdspi_pkg.sv
// Package with the types and constants shared by the SD SPI host sequencer.
package sdspi_pkg;

    typedef enum logic [2:0] {
        CMD_INIT  = 3'd0,
        CMD_READ  = 3'd1,
        CMD_WRITE = 3'd2,
        CMD_CARD  = 3'd3,
        CMD_WDATA = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_XCHG  = 2'd0,
        KIND_RDATA = 2'd1,
        KIND_WWANT = 2'd2,
        KIND_DONE  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_RESET_TO  = 3'd1,
        ST_VOLTAGE   = 3'd2,
        ST_APP_REJ   = 3'd3,
        ST_CMD_REJ   = 3'd4,
        ST_DATA_REJ  = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_INIT  = 2'd1,
        OP_READ  = 2'd2,
        OP_WRITE = 2'd3
    } t_op;

    typedef enum logic [4:0] {
        PH_IDLE, PH_DUMMY, PH_SEND, PH_POLL, PH_REST, PH_BUSY,
        PH_RD_TOKEN, PH_RD_DATA, PH_RD_TAIL, PH_WR_GAP, PH_WR_TOKEN,
        PH_WR_WANT, PH_WR_DATA, PH_WR_CRC, PH_WR_RESP, PH_WR_BUSY, PH_WR_TAIL
    } t_phase;

    localparam int unsigned CFG_POLL_LIMIT  = 0;
    localparam int unsigned CFG_RETRY_LIMIT = 1;

    localparam logic [7:0] DUMMY_BYTE  = 8'hFF;
    localparam logic [7:0] DATA_TOKEN  = 8'hFE;
    localparam logic [7:0] R1_IDLE     = 8'h01;
    localparam logic [5:0] IDX_CMD0    = 6'd0;
    localparam logic [5:0] IDX_CMD8    = 6'd8;
    localparam logic [5:0] IDX_CMD17   = 6'd17;
    localparam logic [5:0] IDX_CMD24   = 6'd24;
    localparam logic [5:0] IDX_CMD41   = 6'd41;
    localparam logic [5:0] IDX_CMD55   = 6'd55;
    localparam logic [5:0] IDX_CMD58   = 6'd58;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] block_number;
        logic [7:0]  card_byte;
        logic [7:0]  write_data;
    } t_in;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] tx_byte;
        logic       select_low;
        logic       fast_clock;
        logic [7:0] read_byte;
        logic [2:0] status;
        logic       high_capacity;
        logic       last;
    } t_out;

    // Results of one request: up to two items.
    typedef struct packed {
        logic [1:0] count;
        t_out       res0;
        t_out       res1;
    } t_res_pair;

endpackage

// File: hw/rtl/sd_card_spi_host_sequencer_unit.sv
// Top level of the SD card SPI-mode host sequencer.
// The sequencer takes one request per clock while its output buffer has room
// and answers it with zero, one or two results in the same pass: a registered
// request is decoded against the current phase by short combinational logic,
// the state is updated and the results are written into a four-entry output
// buffer. Requests are taken in every cycle while the buffer has room for two
// results, so one request per cycle is sustained as long as the result side
// keeps up. Every byte on the SPI link is asked for as an exchange result, and
// the byte the card returned comes back as a card-byte request. Init sends ten
// dummy bytes with chip select high, then CMD0 (retried), CMD8 with echo
// check, CMD55/ACMD41 until ready, switches to the fast clock and reads the
// OCR with CMD58. Read and write move one block of BLOCK_BYTES bytes. A start
// request aborts whatever runs.
module sd_card_spi_host_sequencer_unit
    import sdspi_pkg::*;
#(
    parameter int unsigned BLOCK_BYTES = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in         i_data,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out        o_data,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    localparam int unsigned BCW = $clog2(BLOCK_BYTES + 1);

    // Input register stage.
    logic       r_in_vld;
    t_in        r_in;
    logic       w_room;
    logic       w_accept;

    // Configuration registers.
    logic [15:0] r_poll_limit;
    logic [15:0] r_retry_limit;

    // Sequencer state.
    t_phase      r_phase, n_phase;
    t_op         r_op, n_op;
    logic [BCW-1:0] r_bcnt, n_bcnt;
    logic [15:0] r_retry, n_retry;
    logic [15:0] r_poll, n_poll;
    logic [7:0]  r_resp [5];
    logic [7:0]  n_resp [5];
    logic [47:0] r_frame, n_frame;
    logic        r_v2, n_v2;
    logic        r_fast, n_fast;

    t_res_pair   w_pair;

    // The input register drains every cycle the buffer has room for two.
    assign o_stall  = r_in_vld && !w_room;
    assign w_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_stall) begin
            r_in_vld <= i_valid;
        end
        if (w_accept) begin
            r_in <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_limit  <= 16'd8;
            r_retry_limit <= 16'd100;
        end else if (i_cfg_we) begin
            if (i_cfg_index == 1'(CFG_POLL_LIMIT)) begin
                r_poll_limit <= i_cfg_data;
            end else begin
                r_retry_limit <= i_cfg_data;
            end
        end
    end

    // Next-state and result logic, one pass per request.
    always_comb begin
        logic [5:0]  ix;
        logic [7:0]  r;
        logic [7:0]  cb;
        logic        fin;
        logic        r1;
        logic        ld_cmd;
        logic [5:0]  c_idx;
        logic [31:0] c_arg;
        logic [7:0]  c_crc;
        logic        fast_set;
        logic        done;
        logic [2:0]  d_st;
        logic        xg;
        logic [7:0]  x_tx;
        logic        x_sel;
        logic        rd_emit;
        logic        ww_emit;
        logic [15:0] np;
        logic        rlen5;

        n_phase = r_phase;
        n_op    = r_op;
        n_bcnt  = r_bcnt;
        n_retry = r_retry;
        n_poll  = r_poll;
        n_resp  = r_resp;
        n_frame = r_frame;
        n_v2    = r_v2;
        n_fast  = r_fast;

        ix       = r_frame[45:40];
        rlen5    = (ix == IDX_CMD8) || (ix == IDX_CMD58);
        r        = r_resp[0];
        cb       = r_in.card_byte;
        fin      = 1'b0;
        r1       = 1'b0;
        ld_cmd   = 1'b0;
        c_idx    = IDX_CMD0;
        c_arg    = '0;
        c_crc    = 8'h95;
        fast_set = 1'b0;
        done     = 1'b0;
        d_st     = ST_OK;
        xg       = 1'b0;
        x_tx     = DUMMY_BYTE;
        x_sel    = 1'b1;
        rd_emit  = 1'b0;
        ww_emit  = 1'b0;
        np       = r_poll + 16'd1;

        if (r_in_vld) begin
            case (t_cmd'(r_in.cmd))
                CMD_INIT: begin
                    n_op    = OP_INIT;
                    n_fast  = 1'b0;
                    n_v2    = 1'b0;
                    n_retry = '0;
                    n_bcnt  = '0;
                    n_phase = PH_DUMMY;
                    xg      = 1'b1;
                    x_sel   = 1'b0;
                end
                CMD_READ: begin
                    n_op   = OP_READ;
                    ld_cmd = 1'b1;
                    c_idx  = IDX_CMD17;
                    c_arg  = r_in.block_number;
                    c_crc  = 8'h00;
                end
                CMD_WRITE: begin
                    n_op   = OP_WRITE;
                    ld_cmd = 1'b1;
                    c_idx  = IDX_CMD24;
                    c_arg  = r_in.block_number;
                    c_crc  = 8'h00;
                end
                CMD_WDATA: begin
                    if (r_phase == PH_WR_WANT) begin
                        n_phase = PH_WR_DATA;
                        xg      = 1'b1;
                        x_tx    = r_in.write_data;
                    end
                end
                CMD_CARD: begin
                    case (r_phase)
                        PH_DUMMY: begin
                            n_bcnt = r_bcnt + 1'b1;
                            if (r_bcnt < BCW'(9)) begin
                                xg    = 1'b1;
                                x_sel = 1'b0;
                            end else if (r_retry_limit == 16'd0) begin
                                done = 1'b1;
                                d_st = ST_RESET_TO;
                            end else begin
                                n_retry = '0;
                                ld_cmd  = 1'b1;
                            end
                        end
                        PH_SEND: begin
                            n_bcnt = r_bcnt + 1'b1;
                            if (r_bcnt < BCW'(5)) begin
                                xg = 1'b1;
                                case (r_bcnt[2:0])
                                    3'd0:    x_tx = r_frame[39:32];
                                    3'd1:    x_tx = r_frame[31:24];
                                    3'd2:    x_tx = r_frame[23:16];
                                    3'd3:    x_tx = r_frame[15:8];
                                    default: x_tx = r_frame[7:0];
                                endcase
                            end else if (r_poll_limit == 16'd0) begin
                                n_resp[0] = DUMMY_BYTE;
                                r         = DUMMY_BYTE;
                                r1        = 1'b1;
                            end else begin
                                n_phase = PH_POLL;
                                n_poll  = '0;
                                xg      = 1'b1;
                            end
                        end
                        PH_POLL: begin
                            n_resp[0] = cb;
                            r         = cb;
                            n_poll    = np;
                            if (!cb[7] || np >= r_poll_limit) begin
                                r1 = 1'b1;
                            end else begin
                                xg = 1'b1;
                            end
                        end
                        PH_REST: begin
                            case (r_bcnt[2:0])
                                3'd1:    n_resp[1] = cb;
                                3'd2:    n_resp[2] = cb;
                                3'd3:    n_resp[3] = cb;
                                3'd4:    n_resp[4] = cb;
                                default: ;
                            endcase
                            n_bcnt = r_bcnt + 1'b1;
                            if (!rlen5 || r_bcnt >= BCW'(4)) begin
                                n_phase = PH_BUSY;
                            end
                            xg = 1'b1;
                        end
                        PH_BUSY: begin
                            if (cb != 8'h00) begin
                                fin = 1'b1;
                            end else begin
                                xg = 1'b1;
                            end
                        end
                        PH_RD_TOKEN: begin
                            if (cb == DATA_TOKEN) begin
                                n_phase = PH_RD_DATA;
                                n_bcnt  = '0;
                            end
                            xg = 1'b1;
                        end
                        PH_RD_DATA: begin
                            rd_emit = 1'b1;
                            n_bcnt  = r_bcnt + 1'b1;
                            if (r_bcnt >= BCW'(BLOCK_BYTES - 1)) begin
                                n_phase = PH_RD_TAIL;
                                n_bcnt  = '0;
                            end
                            xg = 1'b1;
                        end
                        PH_RD_TAIL: begin
                            n_bcnt = r_bcnt + 1'b1;
                            if (r_bcnt < BCW'(2)) begin
                                xg = 1'b1;
                            end else begin
                                done = 1'b1;
                            end
                        end
                        PH_WR_GAP: begin
                            n_phase = PH_WR_TOKEN;
                            xg      = 1'b1;
                            x_tx    = DATA_TOKEN;
                        end
                        PH_WR_TOKEN: begin
                            n_phase = PH_WR_WANT;
                            n_bcnt  = '0;
                            ww_emit = 1'b1;
                        end
                        PH_WR_DATA: begin
                            n_bcnt = r_bcnt + 1'b1;
                            if (r_bcnt < BCW'(BLOCK_BYTES - 1)) begin
                                n_phase = PH_WR_WANT;
                                ww_emit = 1'b1;
                            end else begin
                                n_phase = PH_WR_CRC;
                                n_bcnt  = '0;
                                xg      = 1'b1;
                                x_tx    = 8'h00;
                            end
                        end
                        PH_WR_CRC: begin
                            n_bcnt = r_bcnt + 1'b1;
                            xg     = 1'b1;
                            if (r_bcnt < BCW'(1)) begin
                                x_tx = 8'h00;
                            end else begin
                                n_phase = PH_WR_RESP;
                            end
                        end
                        PH_WR_RESP: begin
                            if (cb[3:1] != 3'd2) begin
                                done = 1'b1;
                                d_st = ST_DATA_REJ;
                            end else begin
                                n_phase = PH_WR_BUSY;
                                xg      = 1'b1;
                            end
                        end
                        PH_WR_BUSY: begin
                            if (cb != 8'h00) begin
                                n_phase = PH_WR_TAIL;
                            end
                            xg = 1'b1;
                        end
                        PH_WR_TAIL: begin
                            done = 1'b1;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end

        // R1 received: early finish on error bit or CMD0 not idle.
        if (r1) begin
            if (r[7] || (ix == IDX_CMD0 && !r[0])) begin
                fin = 1'b1;
            end else if (rlen5) begin
                n_phase = PH_REST;
                n_bcnt  = BCW'(1);
                xg      = 1'b1;
            end else begin
                n_phase = PH_BUSY;
                xg      = 1'b1;
            end
        end

        // Command completion decides the next step of the operation.
        if (fin) begin
            case (r_op)
                OP_INIT: begin
                    if (ix == IDX_CMD0) begin
                        n_retry = r_retry + 16'd1;
                        ld_cmd  = 1'b1;
                        if (r == R1_IDLE) begin
                            c_idx = IDX_CMD8;
                            c_arg = 32'h0000_01AA;
                            c_crc = 8'h87;
                        end else if (n_retry >= r_retry_limit) begin
                            ld_cmd = 1'b0;
                            done   = 1'b1;
                            d_st   = ST_RESET_TO;
                        end
                    end else if (ix == IDX_CMD8) begin
                        if (r == R1_IDLE && !(n_resp[1] == 8'h00 && n_resp[2] == 8'h00
                                && n_resp[3] == 8'h01 && n_resp[4] == 8'hAA)) begin
                            done = 1'b1;
                            d_st = ST_VOLTAGE;
                        end else if (r != 8'h00) begin
                            ld_cmd = 1'b1;
                            c_idx  = IDX_CMD55;
                            c_crc  = 8'h00;
                        end else begin
                            fast_set = 1'b1;
                        end
                    end else if (ix == IDX_CMD55) begin
                        if (r != R1_IDLE) begin
                            done = 1'b1;
                            d_st = ST_APP_REJ;
                        end else begin
                            ld_cmd = 1'b1;
                            c_idx  = IDX_CMD41;
                            c_arg  = 32'h4000_0000;
                            c_crc  = 8'h00;
                        end
                    end else if (ix == IDX_CMD41) begin
                        ld_cmd = 1'b1;
                        c_crc  = 8'h00;
                        if (r != 8'h00) begin
                            c_idx = IDX_CMD55;
                        end else begin
                            fast_set = 1'b1;
                        end
                    end else begin
                        n_v2 = n_resp[1][6];
                        done = 1'b1;
                    end
                end
                OP_READ, OP_WRITE: begin
                    if (r != 8'h00) begin
                        done = 1'b1;
                        d_st = ST_CMD_REJ;
                    end else begin
                        n_phase = (r_op == OP_READ) ? PH_RD_TOKEN : PH_WR_GAP;
                        xg      = 1'b1;
                    end
                end
                default: n_phase = PH_IDLE;
            endcase
        end

        if (fast_set) begin
            n_fast = 1'b1;
            ld_cmd = 1'b1;
            c_idx  = IDX_CMD58;
            c_arg  = '0;
            c_crc  = 8'h00;
        end

        if (ld_cmd) begin
            for (int k = 0; k < 5; k++) begin
                n_resp[k] = 8'h00;
            end
            n_frame = {2'b01, c_idx, c_arg, c_crc};
            n_bcnt  = '0;
            n_poll  = '0;
            n_phase = PH_SEND;
            xg      = 1'b1;
            x_tx    = {2'b01, c_idx};
            x_sel   = 1'b1;
        end

        // Results: a read data byte comes before its exchange.
        w_pair = '0;
        w_pair.res0 = '{kind: KIND_XCHG, tx_byte: DUMMY_BYTE, select_low: 1'b0,
                        fast_clock: n_fast, read_byte: 8'h00, status: ST_OK,
                        high_capacity: 1'b0, last: 1'b0};
        w_pair.res1 = w_pair.res0;
        if (rd_emit) begin
            w_pair.count          = 2'd2;
            w_pair.res0.kind      = KIND_RDATA;
            w_pair.res0.read_byte = cb;
            w_pair.res1.tx_byte   = DUMMY_BYTE;
            w_pair.res1.select_low = 1'b1;
            w_pair.res1.last      = 1'b1;
        end else if (done) begin
            w_pair.count               = 2'd1;
            w_pair.res0.kind           = KIND_DONE;
            w_pair.res0.status         = d_st;
            w_pair.res0.high_capacity  = (r_op == OP_INIT && d_st == ST_OK) ? n_v2 : 1'b0;
            w_pair.res0.last           = 1'b1;
            n_phase = PH_IDLE;
            n_op    = OP_NONE;
        end else if (ww_emit) begin
            w_pair.count     = 2'd1;
            w_pair.res0.kind = KIND_WWANT;
            w_pair.res0.last = 1'b1;
        end else if (xg) begin
            w_pair.count           = 2'd1;
            w_pair.res0.tx_byte    = x_tx;
            w_pair.res0.select_low = x_sel;
            w_pair.res0.last       = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_op    <= OP_NONE;
            r_bcnt  <= '0;
            r_retry <= '0;
            r_poll  <= '0;
            r_frame <= '0;
            r_v2    <= 1'b0;
            r_fast  <= 1'b0;
            for (int k = 0; k < 5; k++) begin
                r_resp[k] <= 8'h00;
            end
        end else if (r_in_vld && w_room) begin
            r_phase <= n_phase;
            r_op    <= n_op;
            r_bcnt  <= n_bcnt;
            r_retry <= n_retry;
            r_poll  <= n_poll;
            r_frame <= n_frame;
            r_v2    <= n_v2;
            r_fast  <= n_fast;
            r_resp  <= n_resp;
        end
    end

    sdspi_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_in_vld && w_room),
        .i_pair  (w_pair),
        .o_room  (w_room),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );
endmodule

// File: hw/rtl/sdspi_out_queue.sv
// Output buffer that hands out the one or two results of each request.
module sdspi_out_queue
    import sdspi_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_res_pair i_pair,
    output logic      o_room,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out      o_data
);
    // Four-entry FIFO; a push needs two free slots.
    t_out       r_mem [4];
    logic [1:0] r_rd;
    logic [1:0] r_wr;
    logic [2:0] r_cnt;
    logic       w_pop;
    logic [2:0] n_cnt;

    assign w_pop   = (r_cnt != 3'd0) && !i_stall;
    assign o_valid = (r_cnt != 3'd0);
    assign o_data  = r_mem[r_rd];
    assign o_room  = (r_cnt <= 3'd2);

    always_comb begin
        n_cnt = r_cnt;
        if (w_pop) begin
            n_cnt = n_cnt - 3'd1;
        end
        if (i_push) begin
            n_cnt = n_cnt + {1'b0, i_pair.count};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (w_pop) begin
                r_rd <= r_rd + 2'd1;
            end
            if (i_push) begin
                r_wr <= r_wr + i_pair.count;
            end
        end
        if (i_push && i_pair.count != 2'd0) begin
            r_mem[r_wr] <= i_pair.res0;
            if (i_pair.count == 2'd2) begin
                r_mem[r_wr + 2'd1] <= i_pair.res1;
            end
        end
    end
endmodule

// File: tb/tb.sv
// Self-checking testbench for the SD card SPI-mode host sequencer.
module tb;
    import sdspi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned BLOCK_BYTES = 512;
    localparam int unsigned CYCLE_LIMIT = 800000;
    // Cycles to let pass after the last result.
    localparam int unsigned SETTLE_CYCLES = 12;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    t_in         i_data;
    logic        o_valid;
    logic        i_stall;
    t_out        o_data;
    logic        i_cfg_we;
    logic [0:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    sd_card_spi_host_sequencer_unit #(.BLOCK_BYTES(BLOCK_BYTES)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Results the sequencer still owes us, oldest first.
    t_out pending_results[$];

    int unsigned fail_count;
    int unsigned cycle_count;
    int unsigned requests_sent;
    int unsigned results_seen;
    int unsigned ops_done;
    int unsigned snd_idle_pct;
    int unsigned rcv_idle_pct;
    int unsigned rcv_hold;
    int unsigned card_good_pct;

    // ------------------------------------------------------------------
    // Shadow copy of the sequencer: configuration and state.
    // ------------------------------------------------------------------
    logic [15:0] poll_limit;
    logic [15:0] retry_limit;
    t_phase      sh_phase;
    t_op         sh_op;
    int unsigned byte_cnt;
    logic [15:0] retry_cnt;
    int unsigned poll_cnt;
    logic [7:0]  resp[5];
    logic [47:0] frame;
    logic        hc_flag;
    logic        fast_flag;

    t_out        step_res[2];
    int unsigned step_n;

    function automatic void put(t_kind k, logic [7:0] tx, logic sel, logic [7:0] rb,
                                t_status st, logic hc);
        t_out r;
        if (step_n < 2) begin
            r.kind          = k;
            r.tx_byte       = tx;
            r.select_low    = sel;
            r.fast_clock    = fast_flag;
            r.read_byte     = rb;
            r.status        = st;
            r.high_capacity = hc;
            r.last          = 1'b0;
            step_res[step_n] = r;
            step_n++;
        end
    endfunction

    function automatic void xchg(logic [7:0] tx, logic sel);
        put(KIND_XCHG, tx, sel, 8'h00, ST_OK, 1'b0);
    endfunction

    function automatic void finish_op(t_status st);
        logic hc;
        hc = (sh_op == OP_INIT && st == ST_OK) ? hc_flag : 1'b0;
        put(KIND_DONE, DUMMY_BYTE, 1'b0, 8'h00, st, hc);
        sh_phase = PH_IDLE;
        sh_op    = OP_NONE;
    endfunction

    function automatic logic [7:0] frame_byte(int unsigned i);
        return frame[8*(5-i) +: 8];
    endfunction

    function automatic logic [5:0] cmd_idx();
        return frame[45:40];
    endfunction

    function automatic int unsigned resp_len();
        return (cmd_idx() == IDX_CMD8 || cmd_idx() == IDX_CMD58) ? 5 : 1;
    endfunction

    function automatic void start_cmd(logic [5:0] idx, logic [31:0] arg, logic [7:0] crc);
        foreach (resp[i]) resp[i] = 8'h00;
        frame    = {2'b01, idx, arg, crc};
        byte_cnt = 0;
        poll_cnt = 0;
        sh_phase = PH_SEND;
        xchg(frame_byte(0), 1'b1);
    endfunction

    function automatic void go_fast_ocr();
        fast_flag = 1'b1;
        start_cmd(IDX_CMD58, 32'h0, 8'h00);
    endfunction

    // Decide what follows a completed command, per operation.
    function automatic void cmd_finished();
        logic [5:0] ix;
        logic [7:0] r;
        ix = cmd_idx();
        r  = resp[0];
        if (sh_op == OP_INIT) begin
            if (ix == IDX_CMD0) begin
                retry_cnt = retry_cnt + 16'd1;
                if (r == R1_IDLE)
                    start_cmd(IDX_CMD8, 32'h0000_01AA, 8'h87);
                else if (retry_cnt >= retry_limit)
                    finish_op(ST_RESET_TO);
                else
                    start_cmd(IDX_CMD0, 32'h0, 8'h95);
            end else if (ix == IDX_CMD8) begin
                if (r == R1_IDLE && !(resp[1] == 8'h00 && resp[2] == 8'h00 &&
                                      resp[3] == 8'h01 && resp[4] == 8'hAA))
                    finish_op(ST_VOLTAGE);
                else if (r != 8'h00)
                    start_cmd(IDX_CMD55, 32'h0, 8'h00);
                else
                    go_fast_ocr();
            end else if (ix == IDX_CMD55) begin
                if (r != R1_IDLE)
                    finish_op(ST_APP_REJ);
                else
                    start_cmd(IDX_CMD41, 32'h4000_0000, 8'h00);
            end else if (ix == IDX_CMD41) begin
                if (r != 8'h00)
                    start_cmd(IDX_CMD55, 32'h0, 8'h00);
                else
                    go_fast_ocr();
            end else begin
                hc_flag = resp[1][6];
                finish_op(ST_OK);
            end
        end else if (sh_op == OP_READ || sh_op == OP_WRITE) begin
            if (r != 8'h00) begin
                finish_op(ST_CMD_REJ);
            end else begin
                sh_phase = (sh_op == OP_READ) ? PH_RD_TOKEN : PH_WR_GAP;
                xchg(DUMMY_BYTE, 1'b1);
            end
        end else begin
            sh_phase = PH_IDLE;
        end
    endfunction

    function automatic void got_r1();
        logic [7:0] r;
        r = resp[0];
        if (r[7] || (cmd_idx() == IDX_CMD0 && !r[0])) begin
            cmd_finished();
        end else if (resp_len() > 1) begin
            sh_phase = PH_REST;
            byte_cnt = 1;
            xchg(DUMMY_BYTE, 1'b1);
        end else begin
            sh_phase = PH_BUSY;
            xchg(DUMMY_BYTE, 1'b1);
        end
    endfunction

    function automatic void card_byte_in(logic [7:0] cb);
        case (sh_phase)
            PH_DUMMY: begin
                byte_cnt++;
                if (byte_cnt < 10) begin
                    xchg(DUMMY_BYTE, 1'b0);
                end else if (retry_limit == 16'd0) begin
                    finish_op(ST_RESET_TO);
                end else begin
                    retry_cnt = 16'd0;
                    start_cmd(IDX_CMD0, 32'h0, 8'h95);
                end
            end
            PH_SEND: begin
                byte_cnt++;
                if (byte_cnt < 6) begin
                    xchg(frame_byte(byte_cnt), 1'b1);
                end else if (poll_limit == 16'd0) begin
                    resp[0] = 8'hFF;
                    got_r1();
                end else begin
                    sh_phase = PH_POLL;
                    poll_cnt = 0;
                    xchg(DUMMY_BYTE, 1'b1);
                end
            end
            PH_POLL: begin
                resp[0] = cb;
                poll_cnt++;
                if (!cb[7] || poll_cnt >= poll_limit)
                    got_r1();
                else
                    xchg(DUMMY_BYTE, 1'b1);
            end
            PH_REST: begin
                if (byte_cnt < 5)
                    resp[byte_cnt] = cb;
                byte_cnt++;
                if (byte_cnt >= resp_len())
                    sh_phase = PH_BUSY;
                xchg(DUMMY_BYTE, 1'b1);
            end
            PH_BUSY: begin
                if (cb != 8'h00)
                    cmd_finished();
                else
                    xchg(DUMMY_BYTE, 1'b1);
            end
            PH_RD_TOKEN: begin
                if (cb == DATA_TOKEN) begin
                    sh_phase = PH_RD_DATA;
                    byte_cnt = 0;
                end
                xchg(DUMMY_BYTE, 1'b1);
            end
            PH_RD_DATA: begin
                put(KIND_RDATA, DUMMY_BYTE, 1'b0, cb, ST_OK, 1'b0);
                byte_cnt++;
                if (byte_cnt >= BLOCK_BYTES) begin
                    sh_phase = PH_RD_TAIL;
                    byte_cnt = 0;
                end
                xchg(DUMMY_BYTE, 1'b1);
            end
            PH_RD_TAIL: begin
                byte_cnt++;
                if (byte_cnt < 3)
                    xchg(DUMMY_BYTE, 1'b1);
                else
                    finish_op(ST_OK);
            end
            PH_WR_GAP: begin
                sh_phase = PH_WR_TOKEN;
                xchg(DATA_TOKEN, 1'b1);
            end
            PH_WR_TOKEN: begin
                sh_phase = PH_WR_WANT;
                byte_cnt = 0;
                put(KIND_WWANT, DUMMY_BYTE, 1'b0, 8'h00, ST_OK, 1'b0);
            end
            PH_WR_DATA: begin
                byte_cnt++;
                if (byte_cnt < BLOCK_BYTES) begin
                    sh_phase = PH_WR_WANT;
                    put(KIND_WWANT, DUMMY_BYTE, 1'b0, 8'h00, ST_OK, 1'b0);
                end else begin
                    sh_phase = PH_WR_CRC;
                    byte_cnt = 0;
                    xchg(8'h00, 1'b1);
                end
            end
            PH_WR_CRC: begin
                byte_cnt++;
                if (byte_cnt < 2) begin
                    xchg(8'h00, 1'b1);
                end else begin
                    sh_phase = PH_WR_RESP;
                    xchg(DUMMY_BYTE, 1'b1);
                end
            end
            PH_WR_RESP: begin
                if (cb[3:1] != 3'b010) begin
                    finish_op(ST_DATA_REJ);
                end else begin
                    sh_phase = PH_WR_BUSY;
                    xchg(DUMMY_BYTE, 1'b1);
                end
            end
            PH_WR_BUSY: begin
                if (cb != 8'h00)
                    sh_phase = PH_WR_TAIL;
                xchg(DUMMY_BYTE, 1'b1);
            end
            PH_WR_TAIL: finish_op(ST_OK);
            default: ;
        endcase
    endfunction

    // Apply one accepted request to the shadow state and queue its results.
    function automatic void predict_request(t_in req);
        step_n = 0;
        case (req.cmd)
            CMD_INIT: begin
                sh_op     = OP_INIT;
                fast_flag = 1'b0;
                hc_flag   = 1'b0;
                retry_cnt = 16'd0;
                byte_cnt  = 0;
                sh_phase  = PH_DUMMY;
                xchg(DUMMY_BYTE, 1'b0);
            end
            CMD_READ: begin
                sh_op = OP_READ;
                start_cmd(IDX_CMD17, req.block_number, 8'h00);
            end
            CMD_WRITE: begin
                sh_op = OP_WRITE;
                start_cmd(IDX_CMD24, req.block_number, 8'h00);
            end
            CMD_CARD: begin
                if (sh_phase != PH_IDLE && sh_phase != PH_WR_WANT)
                    card_byte_in(req.card_byte);
            end
            CMD_WDATA: begin
                if (sh_phase == PH_WR_WANT) begin
                    sh_phase = PH_WR_DATA;
                    xchg(req.write_data, 1'b1);
                end
            end
            default: ;
        endcase
        if (step_n > 0)
            step_res[step_n-1].last = 1'b1;
        for (int unsigned i = 0; i < step_n; i++) begin
            if (step_res[i].kind == KIND_DONE)
                ops_done++;
            pending_results.push_back(step_res[i]);
        end
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every accepted result is matched against the oldest
    // expectation, field by field.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("unexpected result with nothing pending: %p", o_data);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_data.kind != want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, o_data.kind);
                    fail_count++;
                end
                if (o_data.tx_byte != want.tx_byte) begin
                    $error("tx_byte: expected %h, got %h", want.tx_byte, o_data.tx_byte);
                    fail_count++;
                end
                if (o_data.select_low != want.select_low) begin
                    $error("select_low: expected %0d, got %0d",
                           want.select_low, o_data.select_low);
                    fail_count++;
                end
                if (o_data.fast_clock != want.fast_clock) begin
                    $error("fast_clock: expected %0d, got %0d",
                           want.fast_clock, o_data.fast_clock);
                    fail_count++;
                end
                if (o_data.read_byte != want.read_byte) begin
                    $error("read_byte: expected %h, got %h", want.read_byte, o_data.read_byte);
                    fail_count++;
                end
                if (o_data.status != want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_data.status);
                    fail_count++;
                end
                if (o_data.high_capacity != want.high_capacity) begin
                    $error("high_capacity: expected %0d, got %0d",
                           want.high_capacity, o_data.high_capacity);
                    fail_count++;
                end
                if (o_data.last != want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_data.last);
                    fail_count++;
                end
            end
        end
    end

    // Receiver back-pressure: random stalls, or a long counted hold-off.
    always @(posedge i_clk) begin
        if (rcv_hold > 0) begin
            i_stall  <= 1'b1;
            rcv_hold <= rcv_hold - 1;
        end else begin
            i_stall <= ($urandom_range(99) < rcv_idle_pct);
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Shared driving tasks.
    // ------------------------------------------------------------------

    // Offer one request, with an optional idle gap first, and hold it until
    // the sequencer takes it. Called right after a rising edge.
    task automatic send_request(t_in req);
        int unsigned gap;
        gap = ($urandom_range(99) < snd_idle_pct) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= req;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        requests_sent++;
        predict_request(req);
    endtask

    task automatic go_quiet();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Sender pauses until every expected result has come back.
    task automatic drain();
        go_quiet();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(int unsigned idx, logic [15:0] val);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx[0:0];
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_POLL_LIMIT)
            poll_limit = val;
        else
            retry_limit = val;
    endtask

    function automatic t_in make_req(t_cmd c);
        t_in r;
        r.cmd          = c;
        r.block_number = $urandom;
        r.card_byte    = $urandom;
        r.write_data   = $urandom;
        return r;
    endfunction

    // What a well-behaved card would return in the current phase; with some
    // probability it returns garbage instead to reach the error paths.
    function automatic logic [7:0] card_answer();
        logic [7:0] any;
        any = $urandom;
        if ($urandom_range(99) >= card_good_pct)
            return any;
        case (sh_phase)
            PH_POLL: begin
                if ($urandom_range(4) == 0)
                    return 8'hFF;
                case (cmd_idx())
                    IDX_CMD0, IDX_CMD8, IDX_CMD55: return R1_IDLE;
                    IDX_CMD41: return ($urandom_range(2) == 0) ? 8'h00 : R1_IDLE;
                    default: return 8'h00;
                endcase
            end
            PH_REST: begin
                if (cmd_idx() == IDX_CMD8) begin
                    case (byte_cnt)
                        1, 2:    return 8'h00;
                        3:       return 8'h01;
                        default: return 8'hAA;
                    endcase
                end
                return any;
            end
            PH_BUSY:     return ($urandom_range(4) == 0) ? 8'h00 : 8'hFF;
            PH_RD_TOKEN: return ($urandom_range(3) == 0) ? 8'hFF : DATA_TOKEN;
            PH_WR_RESP:  return {any[7:4], 3'b010, 1'b1};
            PH_WR_BUSY:  return ($urandom_range(1) == 0) ? 8'h00 : any;
            default:     return any;
        endcase
    endfunction

    // Start an operation and play the card until it completes or the budget
    // runs out (the next start request then aborts it).
    task automatic run_operation(t_cmd start, int unsigned budget);
        t_in req;
        int unsigned used;
        send_request(make_req(start));
        used = 1;
        while (sh_op != OP_NONE && used < budget) begin
            if ($urandom_range(99) < 2) begin
                // Stray request: unknown code, or a byte nobody asked for.
                req = make_req(t_cmd'(($urandom_range(1) == 0) ? $urandom_range(5, 7)
                                      : ((sh_phase == PH_WR_WANT) ? CMD_CARD : CMD_WDATA)));
            end else if (sh_phase == PH_WR_WANT) begin
                req = make_req(CMD_WDATA);
            end else begin
                req = make_req(CMD_CARD);
                req.card_byte = card_answer();
            end
            send_request(req);
            used++;
        end
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Requests that must be ignored while idle.
    task automatic test_stray_requests();
        t_in req;
        for (int c = 3; c <= 7; c++) begin
            req = make_req(t_cmd'(c));
            send_request(req);
        end
        drain();
    endtask

    // Zero and maximum limits during initialization.
    task automatic test_limit_extremes();
        card_good_pct = 100;
        write_cfg(CFG_RETRY_LIMIT, 16'd0);
        run_operation(CMD_INIT, 40);
        write_cfg(CFG_POLL_LIMIT, 16'd0);
        write_cfg(CFG_RETRY_LIMIT, 16'd1);
        run_operation(CMD_INIT, 40);
        write_cfg(CFG_POLL_LIMIT, 16'hFFFF);
        write_cfg(CFG_RETRY_LIMIT, 16'hFFFF);
        run_operation(CMD_INIT, 200);
        drain();
    endtask

    // One complete read and write with a clean card.
    task automatic test_block_transfers();
        card_good_pct = 100;
        write_cfg(CFG_POLL_LIMIT, 16'd8);
        write_cfg(CFG_RETRY_LIMIT, 16'd100);
        run_operation(CMD_READ, 1200);
        run_operation(CMD_WRITE, 1200);
        drain();
    endtask

    // Receiver holds off a long while so the sequencer fills and stalls.
    task automatic test_backpressure();
        snd_idle_pct = 0;
        @(negedge i_clk);
        rcv_hold = 300;
        @(posedge i_clk);
        run_operation(CMD_INIT, 60);
        drain();
    endtask

    // Mixed operations with a noisy card; limits change between phases.
    task automatic test_random_traffic(int unsigned n_items, int unsigned s_pct,
                                       int unsigned r_pct);
        int unsigned start_count;
        int unsigned pick;
        snd_idle_pct  = s_pct;
        rcv_idle_pct  = r_pct;
        card_good_pct = 90;
        start_count   = requests_sent;
        write_cfg(CFG_POLL_LIMIT, 16'($urandom_range(1, 12)));
        write_cfg(CFG_RETRY_LIMIT, 16'($urandom_range(1, 4)));
        while (requests_sent - start_count < n_items) begin
            pick = $urandom_range(99);
            if (pick < 55)
                run_operation(CMD_INIT, $urandom_range(20, 150));
            else if (pick < 80)
                run_operation(CMD_READ, $urandom_range(10, 120));
            else
                run_operation(CMD_WRITE, $urandom_range(10, 120));
        end
        drain();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_data        = '0;
        i_stall       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        fail_count    = 0;
        cycle_count   = 0;
        requests_sent = 0;
        results_seen  = 0;
        ops_done      = 0;
        rcv_hold      = 0;
        snd_idle_pct  = 0;
        rcv_idle_pct  = 0;
        card_good_pct = 100;
        poll_limit    = 16'd8;
        retry_limit   = 16'd100;
        sh_phase      = PH_IDLE;
        sh_op         = OP_NONE;
        byte_cnt      = 0;
        retry_cnt     = 16'd0;
        poll_cnt      = 0;
        foreach (resp[i]) resp[i] = 8'h00;
        frame         = '0;
        hc_flag       = 1'b0;
        fast_flag     = 1'b0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_stray_requests();
        test_limit_extremes();
        test_block_transfers();
        test_backpressure();
        test_random_traffic(50, 37, 80);
        test_random_traffic(50, 80, 37);
        test_random_traffic(50, 0, 0);

        drain();
        $display("Covered %0d requests, %0d results checked, %0d operations completed,",
                 requests_sent, results_seen, ops_done);
        $display("including limit extremes, full block transfers and back-pressure.");
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
